/* sv/piecewise_linear_calibration_lookup_macros.svh */
// ---------------------------------------------------------------------------
// Calibration lookup assertion macros
// Shorthand for the clocked properties of the port checker.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CALIBRATION_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_CALIBRATION_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLCL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plcl: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PLCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plcl: next-cycle property failed");

`endif

/* sv/plcl_pkg.sv */
// ---------------------------------------------------------------------------
// Calibration lookup package
// Sizes, codes and shared types of the piecewise linear calibration lookup.
// ---------------------------------------------------------------------------
package plcl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int KEY_W       = 16;
  localparam int COORD_W     = 16;
  localparam int INDEX_W     = 4;
  localparam int ENTRY_W     = KEY_W + 2 * COORD_W;
  localparam int CFG_COUNT_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int FRAC_W      = 16;
  localparam int T_W         = FRAC_W + 1;
  localparam int PROD_W      = T_W + COORD_W;
  localparam int DIV_STEP_W  = $clog2(FRAC_W);

  localparam logic [COORD_W-1:0] PIVOT_RESET = COORD_W'(32768);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRIES = 2'd0,
    REG_PIVOT_X = 2'd1,
    REG_PIVOT_Y = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  num;
    logic [KEY_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

endpackage

/* sv/plcl_if.sv */
// ---------------------------------------------------------------------------
// Calibration lookup channels
// Request and result channels with a valid and ready handshake.
// ---------------------------------------------------------------------------
interface plcl_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [plcl_pkg::INDEX_W-1:0] entry_index;
  logic signed [plcl_pkg::KEY_W-1:0]   entry_key;
  logic        [plcl_pkg::COORD_W-1:0] entry_x;
  logic        [plcl_pkg::COORD_W-1:0] entry_y;
  logic signed [plcl_pkg::KEY_W-1:0]   lookup_value;

  modport source (
    output valid, req_type, entry_index, entry_key, entry_x, entry_y, lookup_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_key, entry_x, entry_y, lookup_value,
    output ready
  );
endinterface

interface plcl_res_if;
  logic                                valid;
  logic                                ready;
  logic        [plcl_pkg::COORD_W-1:0] pos_x;
  logic        [plcl_pkg::COORD_W-1:0] pos_y;
  logic                                was_clamped;

  modport source (
    output valid, pos_x, pos_y, was_clamped,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, was_clamped,
    output ready
  );
endinterface

/* sv/piecewise_linear_calibration_lookup.sv */
// ---------------------------------------------------------------------------
// Piecewise linear calibration lookup
// Breakpoint table with a serial bracket search, a serial divider and one
// shared multiplier for the interpolation of x and y.
// ---------------------------------------------------------------------------
// The req channel carries two kinds of item. A write item stores one
// breakpoint in the table in the cycle it is accepted and gives no result.
// A lookup item gives one item on the res channel.
// The block takes one item at a time; req.ready is high only when no lookup
// is in progress. A lookup goes to S_FINISH for an empty table, via S_FIRST
// for a value at or below the first key, via S_FIRST and S_LAST at or above
// the last key, and via S_FIRST, S_LAST, S_SEARCH, S_DIVIDE, S_MUL_X,
// S_MUL_Y and S_ADD_Y when interpolating; S_SEARCH visits k keys (1 to
// n-1) of the table RAM, one read per cycle, and S_DIVIDE waits on the
// divider for the fraction t. A bracket that needs no division skips
// S_DIVIDE. The next item is taken in the cycle the result appears, so a
// lookup holds the block; a write item does not. A result waits in an output
// register while res.ready is low; the block still accepts write items
// then, and a finished lookup holds in its last step until the register
// is free. The user must write the configuration through cfg_we, cfg_index
// and cfg_wdata only while the block is idle; the block does not check.
// Reset clears the configuration to an empty table with pivot 0.5, 0.5 and
// empties the pipeline; the table contents are undefined until written.
// ---------------------------------------------------------------------------
module piecewise_linear_calibration_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [plcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  plcl_req_if.sink                          req,
  plcl_res_if.source                        res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_DIVIDE,
    S_MUL_X,
    S_MUL_Y,
    S_ADD_Y,
    S_FINISH
  } state_t;

  state_t state;

  logic [plcl_pkg::CFG_COUNT_W-1:0] entries_in_use;
  logic [plcl_pkg::COORD_W-1:0]     pivot_x;
  logic [plcl_pkg::COORD_W-1:0]     pivot_y;

  logic [plcl_pkg::COUNT_W-1:0]     n_sat;
  logic [plcl_pkg::ADDR_W-1:0]      last_idx;
  logic [plcl_pkg::ADDR_W-1:0]      idx;
  logic signed [plcl_pkg::KEY_W-1:0] v;
  logic signed [plcl_pkg::KEY_W-1:0] ka;
  logic [plcl_pkg::COORD_W-1:0]     xa;
  logic [plcl_pkg::COORD_W-1:0]     ya;
  logic [plcl_pkg::COORD_W-1:0]     xb;
  logic [plcl_pkg::COORD_W-1:0]     yb;
  logic [plcl_pkg::T_W-1:0]         t;
  logic [plcl_pkg::PROD_W-1:0]      prod;
  logic [plcl_pkg::COORD_W-1:0]     fin_x;
  logic [plcl_pkg::COORD_W-1:0]     fin_y;
  logic                             fin_clamp;

  logic                             res_valid;
  logic [plcl_pkg::COORD_W-1:0]     res_x;
  logic [plcl_pkg::COORD_W-1:0]     res_y;
  logic                             res_clamp;

  logic                             ram_we;
  logic [plcl_pkg::ADDR_W-1:0]      ram_waddr;
  logic [plcl_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [plcl_pkg::ADDR_W-1:0]      ram_raddr;
  logic [plcl_pkg::ENTRY_W-1:0]     ram_rdata;

  logic signed [plcl_pkg::KEY_W-1:0] rkey;
  logic [plcl_pkg::COORD_W-1:0]     rx;
  logic [plcl_pkg::COORD_W-1:0]     ry;
  logic                             accept;
  logic                             hit;
  logic signed [plcl_pkg::KEY_W:0]  v_minus_a;
  logic signed [plcl_pkg::KEY_W:0]  b_minus_a;
  logic [plcl_pkg::COORD_W-1:0]     mag;
  logic [plcl_pkg::COORD_W-1:0]     step;
  logic [plcl_pkg::COORD_W-1:0]     lerp_x;
  logic [plcl_pkg::COORD_W-1:0]     lerp_y;

  plcl_pkg::div_req_t               div_req;
  plcl_pkg::div_rsp_t               div_rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      pivot_x        <= plcl_pkg::PIVOT_RESET;
      pivot_y        <= plcl_pkg::PIVOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plcl_pkg::REG_ENTRIES: entries_in_use <= cfg_wdata[plcl_pkg::CFG_COUNT_W-1:0];
        plcl_pkg::REG_PIVOT_X: pivot_x        <= cfg_wdata;
        plcl_pkg::REG_PIVOT_Y: pivot_y        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(entries_in_use) > plcl_pkg::MAX_ENTRIES) begin
      n_sat = plcl_pkg::COUNT_W'(plcl_pkg::MAX_ENTRIES);
    end else begin
      n_sat = plcl_pkg::COUNT_W'(entries_in_use);
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign ram_we    = accept && (req.req_type == plcl_pkg::REQ_WRITE) &&
                     (32'(req.entry_index) < plcl_pkg::MAX_ENTRIES);
  assign ram_waddr = plcl_pkg::ADDR_W'(req.entry_index);
  assign ram_wdata = {req.entry_key, req.entry_x, req.entry_y};

  always_comb begin
    unique case (state)
      S_FIRST:  ram_raddr = last_idx;
      S_LAST:   ram_raddr = plcl_pkg::ADDR_W'(1);
      S_SEARCH: ram_raddr = idx + plcl_pkg::ADDR_W'(1);
      default:  ram_raddr = '0;
    endcase
  end

  plcl_ram #(
    .WIDTH (plcl_pkg::ENTRY_W),
    .DEPTH (plcl_pkg::MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rkey = $signed(ram_rdata[plcl_pkg::ENTRY_W-1 -: plcl_pkg::KEY_W]);
  assign rx   = ram_rdata[2*plcl_pkg::COORD_W-1 -: plcl_pkg::COORD_W];
  assign ry   = ram_rdata[plcl_pkg::COORD_W-1:0];

  assign hit       = (rkey >= v) || (idx == last_idx);
  assign v_minus_a = {v[plcl_pkg::KEY_W-1], v} - {ka[plcl_pkg::KEY_W-1], ka};
  assign b_minus_a = {rkey[plcl_pkg::KEY_W-1], rkey} - {ka[plcl_pkg::KEY_W-1], ka};

  always_comb begin
    div_req.start = (state == S_SEARCH) && hit && (rkey > ka) && (v > ka) && (v < rkey);
    div_req.num   = plcl_pkg::KEY_W'(v_minus_a);
    div_req.den   = plcl_pkg::KEY_W'(b_minus_a);
  end

  plcl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // One multiplier serves x in S_MUL_X and y in S_MUL_Y.
  always_comb begin
    if (state == S_MUL_X) begin
      mag = (xb >= xa) ? (xb - xa) : (xa - xb);
    end else begin
      mag = (yb >= ya) ? (yb - ya) : (ya - yb);
    end
    step   = prod[plcl_pkg::FRAC_W +: plcl_pkg::COORD_W];
    lerp_x = (xb >= xa) ? (xa + step) : (xa - step);
    lerp_y = (yb >= ya) ? (ya + step) : (ya - step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req.req_type == plcl_pkg::REQ_LOOKUP)) begin
            v        <= req.lookup_value;
            last_idx <= plcl_pkg::ADDR_W'(n_sat - plcl_pkg::COUNT_W'(1));
            if (n_sat == '0) begin
              fin_x     <= pivot_x;
              fin_y     <= pivot_y;
              fin_clamp <= 1'b1;
              state     <= S_FINISH;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (v <= rkey) begin
            fin_x     <= rx;
            fin_y     <= ry;
            fin_clamp <= 1'b1;
            state     <= S_FINISH;
          end else begin
            ka    <= rkey;
            xa    <= rx;
            ya    <= ry;
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (v >= rkey) begin
            fin_x     <= rx;
            fin_y     <= ry;
            fin_clamp <= 1'b1;
            state     <= S_FINISH;
          end else begin
            idx   <= plcl_pkg::ADDR_W'(1);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            xb        <= rx;
            yb        <= ry;
            fin_clamp <= 1'b0;
            if ((rkey <= ka) || (v <= ka)) begin
              t     <= '0;
              state <= S_MUL_X;
            end else if (v >= rkey) begin
              t     <= plcl_pkg::T_W'(1) << plcl_pkg::FRAC_W;
              state <= S_MUL_X;
            end else begin
              state <= S_DIVIDE;
            end
          end else begin
            ka  <= rkey;
            xa  <= rx;
            ya  <= ry;
            idx <= idx + plcl_pkg::ADDR_W'(1);
          end
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            t     <= {1'b0, div_rsp.quo};
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          prod  <= t * mag;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          fin_x <= lerp_x;
          prod  <= t * mag;
          state <= S_ADD_Y;
        end
        S_ADD_Y: begin
          fin_y <= lerp_y;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!res_valid || res.ready) begin
            res_x     <= fin_x;
            res_y     <= fin_y;
            res_clamp <= fin_clamp;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.pos_x       = res_x;
  assign res.pos_y       = res_y;
  assign res.was_clamped = res_clamp;

endmodule

/* sv/plcl_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module plcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/plcl_div.sv */
// ---------------------------------------------------------------------------
// Serial fraction divider
// Restoring divider giving floor(num * 2^16 / den) for num below den,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module plcl_div (
  input  logic               clk,
  input  logic               rst,
  input  plcl_pkg::div_req_t req,
  output plcl_pkg::div_rsp_t rsp
);

  logic [plcl_pkg::KEY_W-1:0]      rem;
  logic [plcl_pkg::KEY_W-1:0]      den;
  logic [plcl_pkg::FRAC_W-1:0]     quo;
  logic [plcl_pkg::DIV_STEP_W-1:0] step;
  logic                            running;
  logic                            done;
  logic [plcl_pkg::KEY_W:0]        shifted;
  logic                            fits;
  logic [plcl_pkg::KEY_W-1:0]      rem_next;

  always_comb begin
    shifted  = {rem, 1'b0};
    fits     = shifted >= {1'b0, den};
    rem_next = fits ? plcl_pkg::KEY_W'(shifted - {1'b0, den})
                    : plcl_pkg::KEY_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.num;
        den     <= req.den;
        step    <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem  <= rem_next;
        quo  <= {quo[plcl_pkg::FRAC_W-2:0], fits};
        step <= step + plcl_pkg::DIV_STEP_W'(1);
        if (step == plcl_pkg::DIV_STEP_W'(plcl_pkg::FRAC_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

/* sv/plcl_checker.sv */
// ---------------------------------------------------------------------------
// Calibration lookup port checker
// Watches the channels of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "piecewise_linear_calibration_lookup_macros.svh"

module plcl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           req_type,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [plcl_pkg::COORD_W-1:0]   pos_x,
  input logic [plcl_pkg::COORD_W-1:0]   pos_y,
  input logic                           was_clamped
);

  // A write item never brings out a result.
  `PLCL_ASSERT_NEXT(a_write_no_result, req_valid && req_ready && req_type == plcl_pkg::REQ_WRITE, !$rose(res_valid))

  // A lookup in progress blocks the request channel.
  `PLCL_ASSERT_NEXT(a_busy_after_lookup, req_valid && req_ready && req_type == plcl_pkg::REQ_LOOKUP, !req_ready)

  // A stalled result holds.
  `PLCL_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(pos_x) && $stable(pos_y) && $stable(was_clamped))

  // A new result item appears only as the block returns to idle.
  `PLCL_ASSERT_NOW(a_ready_with_result, $rose(res_valid), req_ready)

endmodule

bind piecewise_linear_calibration_lookup plcl_checker u_plcl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_type    (req.req_type),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .pos_x       (res.pos_x),
  .pos_y       (res.pos_y),
  .was_clamped (res.was_clamped)
);
